[rtl/gllsf_pkg.sv]
// ----------------------------------------------------------------------------
// gllsf_pkg
// shared types, constants and command/status bundles of the gated line fit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gllsf_pkg;

  localparam int MAX_POINTS = 65536;
  localparam int COORD_BITS = 16;
  localparam int CNT_BITS   = 17;
  localparam int MUL_STEPS  = 4;
  localparam int DIV_STEPS  = 33;

  typedef enum logic [1:0] {
    REG_SLOPE_GUESS  = 2'd0,
    REG_OFFSET_GUESS = 2'd1,
    REG_BAND         = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    FIT_VALID    = 2'd0,
    FIT_FEW      = 2'd1,
    FIT_SINGULAR = 2'd2
  } fit_status_t;

  typedef enum logic [2:0] {
    OP_N_SXX,
    OP_SX_SX,
    OP_N_SXY,
    OP_SX_SY,
    OP_SLOPE,
    OP_A_SX,
    OP_ICPT
  } solve_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESID,
    ST_GATE,
    ST_CHECK,
    ST_START,
    ST_MUL,
    ST_DIV,
    ST_DETCHK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic        load;
    logic        resid;
    logic        gate;
    logic        start;
    logic        step;
    logic        store;
    solve_op_t   op;
    logic        set_status;
    fit_status_t status_val;
    logic        out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic few;
    logic det_zero;
    logic done;
    logic out_full;
  } sts_t;

endpackage
`default_nettype wire

[rtl/gated_least_squares_line_fit.sv]
// ----------------------------------------------------------------------------
// gated_least_squares_line_fit
// residual-gated least-squares line fit over a run of points
// ----------------------------------------------------------------------------
// channel  dir  handshake               payload
// s_axis   in   s_tvalid/s_tready       tdata x,y; tlast last_point
// m_axis   out  m_tvalid/m_tready       tdata slope,intercept,count; tuser status
// cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
// each point passes through load, residual multiply, then gate and accumulate
// the last point adds the solve: 5 multiplies on a 64x16 unit
// and two restoring divisions
// the result waits in an output register; a new run may start meanwhile
// reset is synchronous and clears sums, guesses and the output valid
`timescale 1ns / 1ps
`default_nettype none
module gated_least_squares_line_fit (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [31:0] s_tdata,   // point_x, point_y
  input  wire         s_tlast,   // last_point
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [87:0] m_tdata,   // slope, intercept, inlier_count, zero pad
  output logic [1:0]  m_tuser,   // fit_status
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  gllsf_pkg::cmd_t cmd;
  gllsf_pkg::sts_t sts;
  logic [31:0] slope, intercept;
  logic [16:0] inlier_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'b0, inlier_count, intercept, slope};

  gllsf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_fire  (s_tvalid && s_tready),
    .s_ready (s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  gllsf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_fire     (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .point_x      (s_tdata[15:0]),
    .point_y      (s_tdata[31:16]),
    .last_point   (s_tlast),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .fit_status   (m_tuser),
    .slope        (slope),
    .intercept    (intercept),
    .inlier_count (inlier_count)
  );

endmodule
`default_nettype wire

[rtl/gllsf_ctrl.sv]
// ----------------------------------------------------------------------------
// gllsf_ctrl
// sequencer: per-point gating steps and the final solve sequence
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gllsf_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_fire,
  output logic             s_ready,
  input  gllsf_pkg::sts_t  sts,
  output gllsf_pkg::cmd_t  cmd
);

  gllsf_pkg::state_t    state, state_next;
  gllsf_pkg::solve_op_t op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gllsf_pkg::ST_IDLE;
      op    <= gllsf_pkg::OP_N_SXX;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    cmd            = '0;
    cmd.op         = op;
    cmd.status_val = gllsf_pkg::FIT_VALID;
    s_ready        = 1'b0;
    unique case (state)
      gllsf_pkg::ST_IDLE: begin
        s_ready  = 1'b1;
        cmd.load = s_fire;
        if (s_fire) state_next = gllsf_pkg::ST_RESID;
      end
      gllsf_pkg::ST_RESID: begin
        cmd.resid  = 1'b1;
        state_next = gllsf_pkg::ST_GATE;
      end
      gllsf_pkg::ST_GATE: begin
        cmd.gate   = 1'b1;
        state_next = sts.last ? gllsf_pkg::ST_CHECK : gllsf_pkg::ST_IDLE;
      end
      gllsf_pkg::ST_CHECK: begin
        if (sts.few) begin
          cmd.set_status = 1'b1;
          cmd.status_val = gllsf_pkg::FIT_FEW;
          state_next     = gllsf_pkg::ST_OUT;
        end else begin
          op_next    = gllsf_pkg::OP_N_SXX;
          state_next = gllsf_pkg::ST_START;
        end
      end
      gllsf_pkg::ST_START: begin
        cmd.start  = 1'b1;
        state_next = (op == gllsf_pkg::OP_SLOPE || op == gllsf_pkg::OP_ICPT) ?
                     gllsf_pkg::ST_DIV : gllsf_pkg::ST_MUL;
      end
      gllsf_pkg::ST_MUL: begin
        if (sts.done) begin
          cmd.store = 1'b1;
          unique case (op)
            gllsf_pkg::OP_N_SXX: begin
              op_next = gllsf_pkg::OP_SX_SX; state_next = gllsf_pkg::ST_START;
            end
            gllsf_pkg::OP_SX_SX: begin
              op_next = gllsf_pkg::OP_N_SXY; state_next = gllsf_pkg::ST_START;
            end
            gllsf_pkg::OP_N_SXY: begin
              op_next = gllsf_pkg::OP_SX_SY; state_next = gllsf_pkg::ST_START;
            end
            gllsf_pkg::OP_SX_SY: state_next = gllsf_pkg::ST_DETCHK;
            default: begin
              op_next = gllsf_pkg::OP_ICPT; state_next = gllsf_pkg::ST_START;
            end
          endcase
        end else begin
          cmd.step = 1'b1;
        end
      end
      gllsf_pkg::ST_DETCHK: begin
        cmd.set_status = 1'b1;
        if (sts.det_zero) begin
          cmd.status_val = gllsf_pkg::FIT_SINGULAR;
          state_next     = gllsf_pkg::ST_OUT;
        end else begin
          op_next    = gllsf_pkg::OP_SLOPE;
          state_next = gllsf_pkg::ST_START;
        end
      end
      gllsf_pkg::ST_DIV: begin
        if (sts.done) begin
          cmd.store = 1'b1;
          if (op == gllsf_pkg::OP_SLOPE) begin
            op_next    = gllsf_pkg::OP_A_SX;
            state_next = gllsf_pkg::ST_START;
          end else begin
            state_next = gllsf_pkg::ST_OUT;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      gllsf_pkg::ST_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = gllsf_pkg::ST_IDLE;
        end
      end
      default: state_next = gllsf_pkg::ST_IDLE;
    endcase
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_full) else $error("result overwritten");
  a_last_solve: assert property (@(posedge clk) disable iff (rst)
    (state == gllsf_pkg::ST_GATE && sts.last) |=> state == gllsf_pkg::ST_CHECK)
    else $error("last point did not start solve");
  a_store_done: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> sts.done) else $error("store before unit finished");

endmodule
`default_nettype wire

[rtl/gllsf_dp.sv]
// ----------------------------------------------------------------------------
// gllsf_dp
// datapath: guess registers, residual gate, sums, shared multiplier/divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gllsf_dp (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_fire,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  input  wire  [15:0]        point_x,
  input  wire  [15:0]        point_y,
  input  wire                last_point,
  input  gllsf_pkg::cmd_t    cmd,
  output gllsf_pkg::sts_t    sts,
  input  wire                out_ready,
  output logic               out_valid,
  output logic [1:0]         fit_status,
  output logic [31:0]        slope,
  output logic [31:0]        intercept,
  output logic [16:0]        inlier_count
);

  logic [31:0] slope_guess, offset_guess;
  logic [15:0] band_half_width;

  logic signed [15:0] px, py;
  logic               plast;
  logic signed [47:0] prod;

  logic signed [32:0] sum_x, sum_y;
  logic signed [48:0] sum_xx, sum_xy;
  logic [16:0]        n;

  logic [63:0] macc, tmp, det, num, bnum;
  logic [5:0]  cnt;
  logic [63:0] den, rem;
  logic [32:0] qd;
  logic        dneg, dovf;
  logic [31:0] slope_q, icpt_q;
  logic [1:0]  status;

  // residual gate
  logic signed [51:0] dy;
  logic [51:0]        dmag;
  logic               inlier;
  always_comb begin
    dy = 52'(prod) + (52'(signed'(offset_guess)) <<< 4) - (52'(py) <<< 16);
    dmag = dy[51] ? 52'(-dy) : dy;
    inlier = (dmag <= {20'b0, band_half_width, 16'b0}) &&
             (n < 17'(gllsf_pkg::MAX_POINTS));
  end

  // multiplier operands
  logic [63:0] ma, mb;
  logic [15:0] mchunk;
  logic [79:0] mp;
  always_comb begin
    unique case (cmd.op)
      gllsf_pkg::OP_N_SXX: begin ma = 64'(n);  mb = 64'(sum_xx); end
      gllsf_pkg::OP_SX_SX: begin ma = 64'(sum_x); mb = 64'(sum_x); end
      gllsf_pkg::OP_N_SXY: begin ma = 64'(n);  mb = 64'(sum_xy); end
      gllsf_pkg::OP_SX_SY: begin ma = 64'(sum_x); mb = 64'(sum_y); end
      default:             begin ma = 64'(signed'(slope_q)); mb = 64'(sum_x); end
    endcase
    mchunk = mb[{cnt[1:0], 4'b0} +: 16];
    mp     = 80'(ma) * 80'(mchunk);
  end

  // divider setup, trial subtract, rounding and saturation
  logic        is_slope;
  logic [63:0] dnum, dsrc, dabs;
  logic [80:0] dd;
  logic [96:0] dlim;
  logic [64:0] trial;
  logic        qbit;
  logic [33:0] qround;
  logic [32:0] qmag;
  logic [31:0] qsat;
  always_comb begin
    is_slope = (cmd.op == gllsf_pkg::OP_SLOPE);
    dnum     = is_slope ? num : bnum;
    dsrc     = is_slope ? det : {n, 4'b0};
    dabs     = dnum[63] ? (64'd0 - dnum) : dnum;
    dd       = is_slope ? {dabs, 17'b0} : {16'b0, dabs, 1'b0};
    dlim     = is_slope ? {17'b0, dsrc, 16'b0} : {1'b0, dsrc, 32'b0};
    trial    = {rem, qd[32]};
    qbit     = trial >= {1'b0, den};
    qround   = 34'(qd) + 34'd1;
    qmag     = dovf ? 33'h1_0000_0000 : qround[33:1];
    if (dneg) qsat = (qmag >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - qmag);
    else      qsat = (qmag >= 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qmag[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_guess     <= '0;
      offset_guess    <= '0;
      band_half_width <= 16'd16;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        gllsf_pkg::REG_SLOPE_GUESS:  slope_guess     <= cfg_data;
        gllsf_pkg::REG_OFFSET_GUESS: offset_guess    <= cfg_data;
        gllsf_pkg::REG_BAND:         band_half_width <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0; sum_y <= '0; sum_xx <= '0; sum_xy <= '0; n <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.gate && inlier) begin
        sum_x  <= sum_x + 33'(px);
        sum_y  <= sum_y + 33'(py);
        sum_xx <= sum_xx + 49'(px * px);
        sum_xy <= sum_xy + 49'(px * py);
        n      <= n + 17'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
        sum_x <= '0; sum_y <= '0; sum_xx <= '0; sum_xy <= '0; n <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px    <= point_x;
      py    <= point_y;
      plast <= last_point;
    end
    if (cmd.resid) prod <= signed'(slope_guess) * px;
    if (cmd.set_status) status <= cmd.status_val;
    if (cmd.start) begin
      cnt  <= '0;
      macc <= '0;
      dneg <= dnum[63];
      dovf <= {33'b0, dabs} >= dlim;
      den  <= dsrc;
      rem  <= dd[80:33] == 48'd0 ? 64'd0 : 64'(dd[80:33]);
      qd   <= dd[32:0];
    end
    if (cmd.step) begin
      cnt  <= cnt + 6'd1;
      macc <= macc + (mp[63:0] << {cnt[1:0], 4'b0});
      rem  <= qbit ? 64'(trial - {1'b0, den}) : trial[63:0];
      qd   <= {qd[31:0], qbit};
    end
    if (cmd.store) begin
      unique case (cmd.op)
        gllsf_pkg::OP_N_SXX, gllsf_pkg::OP_N_SXY: tmp <= macc;
        gllsf_pkg::OP_SX_SX: det  <= tmp - macc;
        gllsf_pkg::OP_SX_SY: num  <= tmp - macc;
        gllsf_pkg::OP_A_SX:  bnum <= (64'(sum_y) << 16) - macc;
        gllsf_pkg::OP_SLOPE: slope_q <= qsat;
        gllsf_pkg::OP_ICPT:  icpt_q  <= qsat;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      fit_status   <= status;
      slope        <= (status == gllsf_pkg::FIT_VALID) ? slope_q : 32'd0;
      intercept    <= (status == gllsf_pkg::FIT_VALID) ? icpt_q : 32'd0;
      inlier_count <= n;
    end
  end

  always_comb begin
    sts.last     = plast;
    sts.few      = n < 17'd2;
    sts.det_zero = det == 64'd0;
    sts.done     = (cmd.op == gllsf_pkg::OP_SLOPE || cmd.op == gllsf_pkg::OP_ICPT) ?
                   (cnt == 6'(gllsf_pkg::DIV_STEPS)) : (cnt == 6'(gllsf_pkg::MUL_STEPS));
    sts.out_full = out_valid;
  end

endmodule
`default_nettype wire
